FILE: hw/rtl/ilid_pkg.sv
package ilid_pkg;

	localparam int CAPACITY = 128;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int GRP_SIZE = 8;
	localparam int GROUPS   = CAPACITY / GRP_SIZE;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_READ   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_EMPTY = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GATHER,
		ST_OUT
	} state_t;

	// broadcast to every cell in the accept cycle
	typedef struct packed {
		logic             ins_en;
		logic             del_en;
		logic             rd_en;
		logic [POS_W-1:0] pos;
		word_t            value;
	} ilid_ctrl_t;

endpackage

FILE: hw/rtl/ilid_cell.sv
module ilid_cell (
	input  logic                   clk,
	input  ilid_pkg::ilid_ctrl_t   ctrl,
	input  logic [ilid_pkg::POS_W-1:0] cell_idx,
	input  ilid_pkg::word_t        left_value,
	input  ilid_pkg::word_t        right_value,
	output ilid_pkg::word_t        value,
	output ilid_pkg::word_t        rd_word
);
	import ilid_pkg::*;

	word_t value_q;
	logic  at_pos;
	logic  past_pos;

	assign at_pos   = (cell_idx == ctrl.pos);
	assign past_pos = (cell_idx > ctrl.pos);

	// insert: cells past the index take the left neighbor; delete: cells at
	// or past the index take the right neighbor
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && at_pos) begin
			value_q <= ctrl.value;
		end else if (ctrl.ins_en && past_pos) begin
			value_q <= left_value;
		end else if (ctrl.del_en && (at_pos || past_pos)) begin
			value_q <= right_value;
		end
	end

	assign value   = value_q;
	assign rd_word = (ctrl.rd_en && at_pos) ? value_q : '0;

endmodule

FILE: hw/rtl/ilid_rdtree.sv
module ilid_rdtree (
	input  logic            clk,
	input  logic            load,
	input  ilid_pkg::word_t rd_words [ilid_pkg::CAPACITY],
	output ilid_pkg::word_t rd_word
);
	import ilid_pkg::*;

	word_t grp_s1 [GROUPS];

	// only one cell drives a nonzero word, so OR selects it
	for (genvar g = 0; g < GROUPS; g++) begin : g_grp
		word_t grp_or;
		always_comb begin
			grp_or = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				grp_or = grp_or | rd_words[g*GRP_SIZE + k];
			end
		end
		always_ff @(posedge clk) begin
			if (load) begin
				grp_s1[g] <= grp_or;
			end
		end
	end

	always_comb begin
		rd_word = '0;
		for (int g = 0; g < GROUPS; g++) begin
			rd_word = rd_word | grp_s1[g];
		end
	end

endmodule

FILE: hw/rtl/indexed_list_insert_delete.sv
// Channel   Dir  Handshake           Fields
// request   in   in_valid/in_stall   mode, position, new_value
// result    out  out_valid/out_stall status, read_value, count_after
//
// One request at a time: accept, a gather state that takes the read word
// from the registered OR tree, then the result is held until out_stall is
// low. The next is taken the cycle after the result leaves. The shift
// itself happens at the accept edge, in the cells at or past the index.
// arst_n clears the count and the control state; element cells are not
// reset and hold nothing meaningful until written by an insert.
module indexed_list_insert_delete (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ilid_pkg::MODE_W-1:0]   mode,
	input  logic [ilid_pkg::POS_W-1:0]    position,
	input  logic signed [ilid_pkg::DATA_W-1:0] new_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ilid_pkg::STAT_W-1:0]   status,
	output logic signed [ilid_pkg::DATA_W-1:0] read_value,
	output logic [ilid_pkg::POS_W-1:0]    count_after
);
	import ilid_pkg::*;

	state_t           state_q, state_d;
	logic [POS_W-1:0] count_q;
	stat_t            status_q;
	word_t            read_value_q;
	stat_t            stat_d;
	logic             accept;
	ilid_ctrl_t       ctrl;
	word_t            cell_value [CAPACITY];
	word_t            cell_rd    [CAPACITY];
	word_t            tree_word;

	assign accept = in_valid && !in_stall;

	// status decision; full and empty checks come before the index check
	always_comb begin
		stat_d = STAT_OK;
		unique case (mode_t'(mode))
			MODE_READ, MODE_DELETE: begin
				if (count_q == '0) begin
					stat_d = STAT_EMPTY;
				end else if (position >= count_q) begin
					stat_d = STAT_RANGE;
				end
			end
			MODE_INSERT: begin
				if (count_q >= POS_W'(CAPACITY)) begin
					stat_d = STAT_FULL;
				end else if (position > count_q) begin
					stat_d = STAT_RANGE;
				end
			end
			MODE_NONE: stat_d = STAT_OK;
			default:   stat_d = STAT_OK;
		endcase
	end

	always_comb begin
		ctrl.ins_en = accept && (mode_t'(mode) == MODE_INSERT) && (stat_d == STAT_OK);
		ctrl.del_en = accept && (mode_t'(mode) == MODE_DELETE) && (stat_d == STAT_OK);
		ctrl.rd_en  = accept && (mode_t'(mode) == MODE_READ)   && (stat_d == STAT_OK);
		ctrl.pos    = position;
		ctrl.value  = new_value;
	end

	// row of cells; each sees its neighbors, ends are fed zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_value[i-1];
		end
		if (i == CAPACITY-1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_value[i+1];
		end
		ilid_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.cell_idx    (POS_W'(i)),
			.left_value  (left_w),
			.right_value (right_w),
			.value       (cell_value[i]),
			.rd_word     (cell_rd[i])
		);
	end

	ilid_rdtree u_rdtree (
		.clk      (clk),
		.load     (accept),
		.rd_words (cell_rd),
		.rd_word  (tree_word)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_GATHER;
			ST_GATHER: state_d = ST_OUT;
			ST_OUT:    if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall  = 1'b0;
			ST_GATHER: in_stall  = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default:   in_stall  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.ins_en) begin
				count_q <= count_q + POS_W'(1);
			end else if (ctrl.del_en) begin
				count_q <= count_q - POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= stat_d;
		end
		if (state_q == ST_GATHER) begin
			read_value_q <= tree_word;
		end
	end

	assign status      = status_q;
	assign read_value  = read_value_q;
	assign count_after = count_q;

endmodule
